// File: rtl/mbrc_pkg.sv
// shared types and constants for the modbus rtu response checker
package mbrc_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_IDLE  = 2'd3;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_NO_RESP  = 4'd1;
  localparam logic [3:0] ST_INCOMPL  = 4'd2;
  localparam logic [3:0] ST_CRC      = 4'd3;
  localparam logic [3:0] ST_ADDR     = 4'd4;
  localparam logic [3:0] ST_BAD_EXC  = 4'd5;
  localparam logic [3:0] ST_EXC      = 4'd6;
  localparam logic [3:0] ST_FUNC     = 4'd7;
  localparam logic [3:0] ST_ECHO     = 4'd8;
  localparam logic [3:0] ST_BYTE_CNT = 4'd9;

  localparam logic [7:0] FUNC_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] EXC_FLAG = 8'h80;
  localparam logic [6:0] MAX_READ_COUNT = 7'd125;
  localparam logic [16:0] TICK_MAX = 17'h1FFFF;

  localparam logic REG_GAP_TICKS = 1'b0;
  localparam logic REG_FIRST_EXTRA = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [7:0]  slave_addr;
    logic [7:0]  func_code;
    logic [15:0] reg_addr;
    logic [15:0] value_or_count;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  status;
    logic [15:0] data_word;
    logic [6:0]  word_index;
    logic [7:0]  exception_code;
    logic        last;
    logic [31:0] tx_count;
    logic [31:0] rx_count;
    logic [31:0] timeout_count;
    logic [31:0] crc_error_count;
    logic [31:0] exception_count;
  } out_item_t;

  // crc-16/modbus over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/mbrc_front.sv
// front part: transaction state, crc, timing and result forming
module mbrc_front import mbrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  in_item_t    in_item,
  output logic        res_valid,
  output out_item_t   res_item
);

  logic [15:0] gap_ticks, first_extra;
  logic        recv;
  logic [7:0]  bytes_received, expected_length;
  logic [15:0] running_crc;
  logic [16:0] elapsed_ticks;
  logic [7:0]  saved_slave, saved_func, second_byte, third_byte, pending_high_byte;
  logic [15:0] saved_reg_addr, saved_value_count;
  logic        echo_ok, addr_match;
  logic [31:0] tx_cnt, rx_cnt, to_cnt, crc_cnt, exc_cnt;

  logic [6:0]  start_cnt, saved_cnt;
  logic [15:0] crc_new;
  logic [8:0]  idx_p1;
  logic [16:0] ticks_inc, limit;
  logic        is_byte, is_tick, finish, emit_word, timeout;
  logic [3:0]  fin_status;
  logic [7:0]  fin_exc;
  logic [7:0]  b;

  assign b = in_item.data_byte;
  assign start_cnt = (in_item.value_or_count > 16'd125) ? MAX_READ_COUNT
                                                         : in_item.value_or_count[6:0];
  assign saved_cnt = (saved_value_count > 16'd125) ? MAX_READ_COUNT : saved_value_count[6:0];
  assign is_byte = in_valid && recv && in_item.op == OP_BYTE;
  assign is_tick = in_valid && recv && in_item.op == OP_TICK;
  assign crc_new = crc_byte(running_crc, b);
  assign idx_p1 = {1'b0, bytes_received} + 9'd1;
  assign finish = is_byte && ((idx_p1 >= {1'b0, expected_length}) ||
                  (idx_p1 >= 9'd5 && second_byte[7]));
  assign emit_word = is_byte && !finish && saved_func != FUNC_WRITE_SINGLE &&
                     bytes_received >= 8'd3 &&
                     ({1'b0, bytes_received} + 9'd3 <= {1'b0, expected_length}) &&
                     !bytes_received[0];
  assign ticks_inc = (elapsed_ticks < TICK_MAX) ? elapsed_ticks + 17'd1 : elapsed_ticks;
  assign limit = (bytes_received == 8'd0) ? {1'b0, gap_ticks} + {1'b0, first_extra}
                                          : {1'b0, gap_ticks};
  assign timeout = is_tick && ticks_inc >= limit;

  // final verdict in priority order; crc_new is the residue including this byte
  always_comb begin
    fin_status = ST_OK;
    fin_exc = 8'h00;
    if (crc_new != 16'h0000) begin
      fin_status = ST_CRC;
    end else if (!addr_match) begin
      fin_status = ST_ADDR;
    end else if (second_byte[7]) begin
      if (second_byte != (saved_func | EXC_FLAG)) begin
        fin_status = ST_BAD_EXC;
      end else begin
        fin_status = ST_EXC;
        fin_exc = third_byte;
      end
    end else if (second_byte != saved_func) begin
      fin_status = ST_FUNC;
    end else if (saved_func == FUNC_WRITE_SINGLE) begin
      fin_status = echo_ok ? ST_OK : ST_ECHO;
    end else if (third_byte != {saved_cnt, 1'b0}) begin
      fin_status = ST_BYTE_CNT;
    end
  end

  // byte index 0..2 update addr/second/third before finish can see them only when
  // finish happens at index >= 4, so the registered values are already settled
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks <= 16'd5;
      first_extra <= 16'd1000;
      recv <= 1'b0;
      bytes_received <= '0;
      expected_length <= '0;
      running_crc <= 16'hFFFF;
      elapsed_ticks <= '0;
      saved_slave <= '0;
      saved_func <= '0;
      saved_reg_addr <= '0;
      saved_value_count <= '0;
      second_byte <= '0;
      third_byte <= '0;
      pending_high_byte <= '0;
      echo_ok <= 1'b1;
      addr_match <= 1'b1;
      tx_cnt <= '0;
      rx_cnt <= '0;
      to_cnt <= '0;
      crc_cnt <= '0;
      exc_cnt <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= finish || emit_word || timeout;
      if (cfg_we) begin
        if (cfg_idx == REG_GAP_TICKS) gap_ticks <= cfg_data;
        else first_extra <= cfg_data;
      end
      if (in_valid && in_item.op == OP_START) begin
        saved_slave <= in_item.slave_addr;
        saved_func <= in_item.func_code;
        saved_reg_addr <= in_item.reg_addr;
        saved_value_count <= in_item.value_or_count;
        expected_length <= (in_item.func_code == FUNC_WRITE_SINGLE) ? 8'd8
                           : 8'd5 + {start_cnt, 1'b0};
        bytes_received <= '0;
        running_crc <= 16'hFFFF;
        elapsed_ticks <= '0;
        second_byte <= '0;
        third_byte <= '0;
        pending_high_byte <= '0;
        echo_ok <= 1'b1;
        addr_match <= 1'b1;
        tx_cnt <= tx_cnt + 32'd1;
        recv <= 1'b1;
      end
      if (is_byte) begin
        running_crc <= crc_new;
        elapsed_ticks <= '0;
        bytes_received <= idx_p1[7:0];
        case (bytes_received)
          8'd0: addr_match <= (b == saved_slave);
          8'd1: second_byte <= b;
          8'd2: begin
            third_byte <= b;
            if (b != saved_reg_addr[15:8]) echo_ok <= 1'b0;
          end
          8'd3: if (b != saved_reg_addr[7:0]) echo_ok <= 1'b0;
          8'd4: if (b != saved_value_count[15:8]) echo_ok <= 1'b0;
          8'd5: if (b != saved_value_count[7:0]) echo_ok <= 1'b0;
          default: ;
        endcase
        if (!finish && bytes_received[0]) pending_high_byte <= b;
        if (finish) begin
          recv <= 1'b0;
          rx_cnt <= rx_cnt + 32'd1;
          if (fin_status == ST_CRC) crc_cnt <= crc_cnt + 32'd1;
          if (fin_status == ST_EXC) exc_cnt <= exc_cnt + 32'd1;
        end
      end
      if (is_tick) begin
        elapsed_ticks <= ticks_inc;
        if (timeout) begin
          recv <= 1'b0;
          to_cnt <= to_cnt + 32'd1;
        end
      end
    end
  end

  // result payload, counters as they stand after this item
  always_ff @(posedge clk) begin
    res_item.tx_count <= tx_cnt;
    res_item.rx_count <= rx_cnt + {31'd0, finish};
    res_item.timeout_count <= to_cnt + {31'd0, timeout};
    res_item.crc_error_count <= crc_cnt + {31'd0, finish && fin_status == ST_CRC};
    res_item.exception_count <= exc_cnt + {31'd0, finish && fin_status == ST_EXC};
    res_item.kind <= !emit_word;
    res_item.last <= !emit_word;
    res_item.status <= emit_word ? ST_OK : (timeout ? ((bytes_received == 8'd0) ?
                       ST_NO_RESP : ST_INCOMPL) : fin_status);
    res_item.data_word <= emit_word ? {pending_high_byte, b} : 16'h0000;
    res_item.word_index <= emit_word ? 7'((bytes_received - 8'd4) >> 1) : 7'd0;
    res_item.exception_code <= (emit_word || timeout) ? 8'h00 : fin_exc;
  end

endmodule

// File: rtl/mbrc_queue.sv
// result queue between the front part and the output side
module mbrc_queue import mbrc_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  out_item_t wr_item,
  input  logic      rd,
  output out_item_t rd_item,
  output logic      empty,
  output logic      full
);

  localparam int AW = $clog2(Depth);

  out_item_t       mem [Depth];
  logic [AW-1:0]   wp, rp;
  logic [AW:0]     cnt;

  assign empty = (cnt == '0);
  assign full = (cnt == (AW+1)'(Depth));
  assign rd_item = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

endmodule

// File: rtl/modbus_rtu_response_checker_unit.sv
// top level of the modbus rtu master response checker
//   channel  | direction | handshake          | payload
//   request  | in        | push / full        | in_item (in_item_t)
//   result   | out       | pop / empty        | out_item (out_item_t)
//   config   | in        | cfg_we             | cfg_idx, cfg_data
// one request is taken per cycle while full is low; a result passes through the
// front part's output register and the queue memory before it is on the outputs.
// rst clears all counters and state; gap_ticks resets to 5, first byte extra to 1000.
// full rises once QueueDepth-1 results wait, leaving room for one result in flight,
// so a stalled pop holds back push only when the queue is nearly full.
module modbus_rtu_response_checker_unit import mbrc_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  input  logic        pop,
  output logic        empty,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_data
);

  logic      res_valid, q_full, acc;
  out_item_t res_item;
  logic [$clog2(QueueDepth+2):0] used;

  assign acc = push && !full;
  // queued plus one possible result in flight
  assign full = (used >= ($clog2(QueueDepth+2)+1)'(QueueDepth - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + ($clog2(QueueDepth+2)+1)'(res_valid)
                   - ($clog2(QueueDepth+2)+1)'(pop && !empty);
    end
  end

  mbrc_front u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(acc), .in_item(in_item), .res_valid(res_valid), .res_item(res_item)
  );

  mbrc_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .wr(res_valid && !q_full), .wr_item(res_item),
    .rd(pop && !empty), .rd_item(out_item), .empty(empty), .full(q_full)
  );

endmodule

// File: tb/tb_top.sv
// testbench for the modbus rtu response checker: response framing, timeouts and status checks
module tb_top;
  import mbrc_pkg::*;

  localparam int LATENCY = 2;
  localparam int NUM_ITEMS = 600;

  // expected results, checked in order of arrival
  class response_scoreboard;
    out_item_t pending[$];
    int errors;
    int matched;

    function void note_request(out_item_t r);
      pending = {pending, r};
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %h got %h", want, got);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic clk, rst, push, full, pop, empty, cfg_we, cfg_idx;
  logic [15:0] cfg_data;
  in_item_t in_item;
  out_item_t out_item;

  modbus_rtu_response_checker_unit uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .pop(pop), .empty(empty), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  response_scoreboard sb;

  // predictor state
  logic [15:0] gap_cfg, extra_cfg;
  logic receiving;
  logic [7:0] rx_bytes, frame_len, exp_slave, exp_func, byte1, byte2, hi_byte;
  logic [15:0] exp_reg, exp_val, crc_acc;
  logic [16:0] silence;
  logic echo_good, addr_good;
  logic [31:0] n_tx, n_rx, n_to, n_crc, n_exc;
  int stall_pct;
  int n_status;

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic logic [7:0] clipped_count(logic [15:0] v);
    return (v > 16'd125) ? 8'd125 : v[7:0];
  endfunction

  function automatic out_item_t make_result(logic k, logic [3:0] st, logic [15:0] w,
                                            logic [6:0] ix, logic [7:0] ex);
    out_item_t r;
    r.kind = k; r.status = st; r.data_word = w; r.word_index = ix;
    r.exception_code = ex; r.last = k;
    r.tx_count = n_tx; r.rx_count = n_rx; r.timeout_count = n_to;
    r.crc_error_count = n_crc; r.exception_count = n_exc;
    return r;
  endfunction

  function automatic void predict_frame_end();
    logic [3:0] st;
    logic [7:0] ex;
    st = ST_OK; ex = 8'd0;
    receiving = 1'b0;
    n_rx++;
    if (crc_acc != 16'd0) begin
      n_crc++; st = ST_CRC;
    end else if (!addr_good) st = ST_ADDR;
    else if (byte1[7]) begin
      if (byte1 != (exp_func | EXC_FLAG)) st = ST_BAD_EXC;
      else begin n_exc++; st = ST_EXC; ex = byte2; end
    end else if (byte1 != exp_func) st = ST_FUNC;
    else if (exp_func == FUNC_WRITE_SINGLE) st = echo_good ? ST_OK : ST_ECHO;
    else if (byte2 != 8'(2 * clipped_count(exp_val))) st = ST_BYTE_CNT;
    sb.note_request(make_result(1'b1, st, 16'd0, 7'd0, ex));
    n_status++;
  endfunction

  function automatic void predict_request(in_item_t it);
    logic [16:0] lim;
    int ix;
    if (it.op == OP_START) begin
      exp_slave = it.slave_addr; exp_func = it.func_code;
      exp_reg = it.reg_addr; exp_val = it.value_or_count;
      frame_len = (exp_func == FUNC_WRITE_SINGLE) ? 8'd8 : 8'(5 + 2 * clipped_count(exp_val));
      rx_bytes = 0; crc_acc = 16'hFFFF; silence = 0; byte1 = 0; byte2 = 0; hi_byte = 0;
      echo_good = 1; addr_good = 1; n_tx++; receiving = 1;
      return;
    end
    if (!receiving) return;
    if (it.op == OP_BYTE) begin
      ix = rx_bytes;
      crc_acc = crc_step(crc_acc, it.data_byte);
      if (ix == 0) addr_good = (it.data_byte == exp_slave);
      if (ix == 1) byte1 = it.data_byte;
      if (ix == 2) begin
        byte2 = it.data_byte;
        if (it.data_byte != exp_reg[15:8]) echo_good = 0;
      end
      if (ix == 3 && it.data_byte != exp_reg[7:0]) echo_good = 0;
      if (ix == 4 && it.data_byte != exp_val[15:8]) echo_good = 0;
      if (ix == 5 && it.data_byte != exp_val[7:0]) echo_good = 0;
      rx_bytes = 8'(ix + 1);
      silence = 0;
      if (ix + 1 >= frame_len || (ix + 1 >= 5 && byte1[7])) begin
        predict_frame_end();
        return;
      end
      if (exp_func != FUNC_WRITE_SINGLE && ix >= 3 && ix + 3 <= frame_len) begin
        if (ix % 2 == 1) hi_byte = it.data_byte;
        else sb.note_request(make_result(1'b0, ST_OK, {hi_byte, it.data_byte},
                                         7'((ix - 4) / 2), 8'd0));
      end
    end else if (it.op == OP_TICK) begin
      lim = (rx_bytes == 0) ? 17'(gap_cfg) + 17'(extra_cfg) : 17'(gap_cfg);
      if (silence < TICK_MAX) silence++;
      if (silence >= lim) begin
        receiving = 0; n_to++;
        sb.note_request(make_result(1'b1, (rx_bytes == 0) ? ST_NO_RESP : ST_INCOMPL,
                                    16'd0, 7'd0, 8'd0));
        n_status++;
      end
    end
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: stalls on its own pattern, rate changes over time
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_result(out_item);
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(in_item_t it);
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_request(it);
  endtask

  task automatic pause_idle();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic gap_maybe(inout int burst);
    int n;
    if (burst > 0) begin
      burst--;
      return;
    end
    n = $urandom_range(4);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
    burst = $urandom_range(20);
  endtask

  function automatic in_item_t rand_item(logic [1:0] op);
    in_item_t it;
    it = '{op: op, data_byte: 8'($urandom), slave_addr: 8'($urandom_range(247, 1)),
           func_code: 8'($urandom), reg_addr: 16'($urandom), value_or_count: 16'($urandom)};
    return it;
  endfunction

  task automatic write_reg(logic idx, logic [15:0] v);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GAP_TICKS) gap_cfg = v; else extra_cfg = v;
  endtask

  // one well-formed or damaged response, with ticks sprinkled between bytes
  task automatic run_transaction(inout int burst, inout int sent);
    in_item_t st, b;
    logic [7:0] fr [$];
    logic [15:0] c;
    int cnt, mode;
    st = rand_item(OP_START);
    mode = $urandom_range(9);
    case ($urandom_range(3))
      0: st.func_code = FUNC_WRITE_SINGLE;
      1: st.func_code = 8'd3;
      2: st.func_code = 8'd4;
      default: ;
    endcase
    if ($urandom_range(9) == 0) st.value_or_count = 16'($urandom_range(300));
    else if (st.func_code != FUNC_WRITE_SINGLE) st.value_or_count = 16'($urandom_range(6));
    cnt = clipped_count(st.value_or_count);
    fr = {fr, st.slave_addr};
    if (mode == 0) begin
      fr = {fr, st.func_code | EXC_FLAG}; fr = {fr, 8'($urandom)};
    end else begin
      fr = {fr, st.func_code};
      if (st.func_code == FUNC_WRITE_SINGLE) begin
        fr = {fr, st.reg_addr[15:8]}; fr = {fr, st.reg_addr[7:0]};
        fr = {fr, st.value_or_count[15:8]}; fr = {fr, st.value_or_count[7:0]};
      end else begin
        fr = {fr, 8'(2 * cnt)};
        for (int i = 0; i < 2 * cnt; i++) fr = {fr, 8'($urandom)};
      end
    end
    if (mode == 1) fr[$urandom_range(fr.size() - 1)] ^= 8'(1 << $urandom_range(7));
    c = 16'hFFFF;
    foreach (fr[i]) c = crc_step(c, fr[i]);
    fr = {fr, c[7:0]}; fr = {fr, c[15:8]};
    if (mode == 2) fr[fr.size() - 1] ^= 8'h01;
    if (mode == 3) fr = fr[0:$urandom_range(fr.size() - 1)];
    send(st); sent++;
    foreach (fr[i]) begin
      gap_maybe(burst);
      if ($urandom_range(7) == 0) begin
        b = rand_item(OP_TICK); send(b); sent++;
      end
      b = rand_item(OP_BYTE); b.data_byte = fr[i]; send(b); sent++;
    end
    if (mode == 3)
      for (int i = 0; i < int'(gap_cfg) + 1 && receiving; i++) begin
        b = rand_item(OP_TICK); send(b); sent++;
      end
  endtask

  initial begin
    in_item_t it;
    int burst, sent, limit;
    sb = new();
    rst = 1; push = 0; cfg_we = 0; cfg_idx = 0; cfg_data = 0; in_item = '0;
    stall_pct = 20; burst = 0; sent = 0; n_status = 0;
    gap_cfg = 16'd5; extra_cfg = 16'd1000; receiving = 0;
    rx_bytes = 0; frame_len = 0; exp_slave = 0; exp_func = 0; byte1 = 0; byte2 = 0;
    hi_byte = 0; exp_reg = 0; exp_val = 0; crc_acc = 16'hFFFF; silence = 0;
    echo_good = 1; addr_good = 1; n_tx = 0; n_rx = 0; n_to = 0; n_crc = 0; n_exc = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle noise, op 3, gap of zero, overlapping starts, count clipping
    it = rand_item(OP_BYTE); send(it);
    it = rand_item(OP_TICK); send(it);
    it = rand_item(OP_IDLE); send(it);
    it = '{op: OP_START, data_byte: 8'hFF, slave_addr: 8'd247, func_code: 8'd3,
           reg_addr: 16'hFFFF, value_or_count: 16'hFFFF};
    send(it);
    it.slave_addr = 8'd1; it.value_or_count = 16'd0; send(it);
    it.op = OP_BYTE; it.data_byte = 8'd1; send(it);
    it.data_byte = 8'd3; send(it);
    it.data_byte = 8'd0; send(it);
    it.data_byte = 8'hFF; send(it); send(it);
    it.op = OP_IDLE; send(it);
    pause_idle();
    write_reg(REG_GAP_TICKS, 16'd0);
    write_reg(REG_FIRST_EXTRA, 16'd0);
    it = rand_item(OP_START); send(it);
    it.op = OP_TICK; send(it);
    pause_idle();
    write_reg(REG_GAP_TICKS, 16'd1);
    it = rand_item(OP_START); send(it);
    it.op = OP_BYTE; send(it);
    it.op = OP_TICK; send(it);
    pause_idle();
    write_reg(REG_GAP_TICKS, 16'hFFFF);
    write_reg(REG_FIRST_EXTRA, 16'hFFFF);
    it = rand_item(OP_START); it.func_code = 8'd4; it.value_or_count = 16'd126; send(it);
    it = rand_item(OP_START); it.func_code = 8'd0; send(it);
    pause_idle();
    write_reg(REG_GAP_TICKS, 16'd3);
    write_reg(REG_FIRST_EXTRA, 16'd2);

    // random phases with different timeouts and stall rates
    for (int ph = 0; ph < 4; ph++) begin
      limit = sent + NUM_ITEMS / 4;
      stall_pct = (ph == 1) ? 0 : (ph == 2) ? 70 : 25;
      while (sent < limit) begin
        if ($urandom_range(5) == 0) begin
          gap_maybe(burst);
          it = rand_item(2'($urandom_range(3)));
          send(it); sent++;
        end else begin
          run_transaction(burst, sent);
        end
      end
      pause_idle();
      repeat (LATENCY + 2) @(posedge clk);
      write_reg(REG_GAP_TICKS, 16'($urandom_range(8, 1)));
      write_reg(REG_FIRST_EXTRA, 16'($urandom_range(6)));
    end
    push <= 1'b0;

    limit = 0;
    while (sb.pending.size() != 0 && limit < 100000) begin
      @(posedge clk);
      limit++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d transactions, %0d status results, %0d results matched", n_tx,
             n_status, sb.matched);
    $display("timeouts %0d, crc errors %0d, exceptions %0d", n_to, n_crc, n_exc);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mbrc_pkg.sv
rtl/mbrc_front.sv
rtl/mbrc_queue.sv
rtl/modbus_rtu_response_checker_unit.sv
tb/tb_top.sv
